// ===== hdl/hbpe_pkg.sv =====
package hbpe_pkg;

  // Fixed field widths of the item channels
  localparam int CMD_W     = 2;
  localparam int SYM_W     = 8;
  localparam int CODE_IN_W = 32;
  localparam int LEN_IN_W  = 6;
  localparam int BYTE_W    = 8;
  localparam int FBITS_W   = 4;
  localparam int TOTAL_W   = 32;

  // Pending-bit store: at most seven bits wait for a byte to fill
  localparam int BUF_W = 7;
  localparam int CNT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  // Access request to the code table
  typedef struct packed {
    logic we;
    logic re;
  } tbl_ctl_t;

endpackage

// ===== hdl/huffman_bit_packing_encoder.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_ready_o command_i symbol_i code_word_i code_length_i
// out      output     out_valid_o/out_ready_i out_byte_o has_byte_o last_o final_bits_o
//                                           byte_total_o
//
// Load writes the table; flush emits a last-marked result; encode reads the code table
// synchronously, then emits n complete bytes (0..4) from the bit accumulator, one byte
// per cycle while the output is free. Input is taken only while the sequencer is idle;
// a result may still wait in the output register then. Reset clears the table valid bits
// at once, so no clearing pass is needed. A stalled output holds the sequencer in place.
module huffman_bit_packing_encoder #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hbpe_pkg::CMD_W-1:0]     command_i,
  input  logic [hbpe_pkg::SYM_W-1:0]     symbol_i,
  input  logic [hbpe_pkg::CODE_IN_W-1:0] code_word_i,
  input  logic [hbpe_pkg::LEN_IN_W-1:0]  code_length_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hbpe_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                           has_byte_o,
  output logic                           last_o,
  output logic [hbpe_pkg::FBITS_W-1:0]   final_bits_o,
  output logic [hbpe_pkg::TOTAL_W-1:0]   byte_total_o
);
  import hbpe_pkg::*;

  localparam int AW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int DW    = MAX_CODE_LEN + LEN_W;
  localparam int ACC_W = MAX_CODE_LEN + BUF_W;
  localparam int TOT_W = $clog2(MAX_CODE_LEN + BYTE_W);

  state_e state_q, state_d;
  logic [BUF_W-1:0]   buf_q, buf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] emitted_q, emitted_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [TOT_W-1:0]   total_q, total_d;

  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic               has_byte_q, has_byte_d;
  logic               last_q, last_d;
  logic [FBITS_W-1:0] final_bits_q, final_bits_d;
  logic [TOTAL_W-1:0] byte_total_q, byte_total_d;

  logic               in_xfer;
  logic               out_free;
  logic               sym_ok;
  cmd_e               cmd;
  tbl_ctl_t           tbl_ctl;
  logic [LEN_W-1:0]   len_sat;
  logic [DW-1:0]      tbl_wdata;
  logic [DW-1:0]      tbl_rdata;
  logic [MAX_CODE_LEN-1:0] code_rd;
  logic [LEN_W-1:0]   len_rd;
  logic [ACC_W-1:0]   acc_new;
  logic [TOT_W-1:0]   tot_new;
  logic [TOT_W-1:0]   rem_tot;
  logic [ACC_W-1:0]   emit_shift;
  logic [BYTE_W-1:0]  flush_byte;
  logic [TOTAL_W-1:0] emitted_inc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cmd        = cmd_e'(command_i);
  assign sym_ok     = {1'b0, symbol_i} < (SYM_W + 1)'(NUM_SYMBOLS);

  // Clamp over-long codes on load
  assign len_sat = (code_length_i > LEN_IN_W'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : code_length_i[LEN_W-1:0];
  assign tbl_wdata = {len_sat, code_word_i[MAX_CODE_LEN-1:0]};

  assign tbl_ctl.we = in_xfer && (cmd == CMD_LOAD) && sym_ok;
  assign tbl_ctl.re = in_xfer && (cmd == CMD_ENCODE) && sym_ok;

  hbpe_code_table #(
    .DEPTH (NUM_SYMBOLS),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tbl_ctl),
    .addr_i  (symbol_i[AW-1:0]),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  assign code_rd = tbl_rdata[MAX_CODE_LEN-1:0];
  assign len_rd  = tbl_rdata[DW-1:MAX_CODE_LEN];

  // Append the looked-up code below the pending bits
  assign acc_new = (ACC_W'(buf_q) << len_rd) |
                   (ACC_W'(code_rd) & ~({ACC_W{1'b1}} << len_rd));
  assign tot_new = TOT_W'(cnt_q) + TOT_W'(len_rd);

  // Oldest complete byte sits just below the running bit total
  assign rem_tot    = total_q - TOT_W'(BYTE_W);
  assign emit_shift = acc_q >> rem_tot;

  assign flush_byte  = {1'b0, buf_q} << (FBITS_W'(BYTE_W) - FBITS_W'(cnt_q));
  assign emitted_inc = (emitted_q != '1) ? emitted_q + TOTAL_W'(1) : emitted_q;

  always_comb begin
    state_d      = state_q;
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    emitted_d    = emitted_q;
    acc_d        = acc_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    has_byte_d   = has_byte_q;
    last_d       = last_q;
    final_bits_d = final_bits_q;
    byte_total_d = byte_total_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd)
            CMD_ENCODE: begin
              if (sym_ok) begin
                state_d = S_READ;
              end
            end
            CMD_FLUSH: begin
              state_d = S_FLUSH;
            end
            default: begin
              // load goes straight to the table; unused code does nothing
            end
          endcase
        end
      end

      S_READ: begin
        if (len_rd == '0) begin
          state_d = S_IDLE;
        end else if (tot_new >= TOT_W'(BYTE_W)) begin
          acc_d   = acc_new;
          total_d = tot_new;
          state_d = S_EMIT;
        end else begin
          // still short of a byte: hold the bits for the next code
          buf_d   = acc_new[BUF_W-1:0];
          cnt_d   = tot_new[CNT_W-1:0];
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = emit_shift[BYTE_W-1:0];
          has_byte_d   = 1'b1;
          last_d       = (rem_tot < TOT_W'(BYTE_W));
          final_bits_d = '0;
          byte_total_d = '0;
          emitted_d    = emitted_inc;
          total_d      = rem_tot;
          if (rem_tot < TOT_W'(BYTE_W)) begin
            buf_d   = acc_q[BUF_W-1:0] & ~({BUF_W{1'b1}} << rem_tot[CNT_W-1:0]);
            cnt_d   = rem_tot[CNT_W-1:0];
            state_d = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (cnt_q != '0) begin
            out_byte_d   = flush_byte;
            has_byte_d   = 1'b1;
            final_bits_d = FBITS_W'(cnt_q);
            byte_total_d = emitted_inc;
          end else begin
            out_byte_d   = '0;
            has_byte_d   = 1'b0;
            final_bits_d = FBITS_W'(BYTE_W);
            byte_total_d = emitted_q;
          end
          buf_d     = '0;
          cnt_d     = '0;
          emitted_d = '0;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      buf_q       <= '0;
      cnt_q       <= '0;
      emitted_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      emitted_q   <= emitted_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    out_byte_q   <= out_byte_d;
    has_byte_q   <= has_byte_d;
    last_q       <= last_d;
    final_bits_q <= final_bits_d;
    byte_total_q <= byte_total_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign has_byte_o   = has_byte_q;
  assign last_o       = last_q;
  assign final_bits_o = final_bits_q;
  assign byte_total_o = byte_total_q;

  // The emit state always holds at least one complete byte
  a_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (total_q >= TOT_W'(BYTE_W)))
    else $error("emit state entered without a full byte");

  // A table read is only in flight right after an encode transfer
  a_read_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(in_valid_i && in_ready_o && tbl_ctl.re))
    else $error("table read state without encode transfer");

  // A flush that finds the output free leaves a last-marked result
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && out_free) |=> (out_valid_o && last_o))
    else $error("flush did not produce a last result");

  // An empty result only comes from an empty flush
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> (last_o && final_bits_o == FBITS_W'(BYTE_W)))
    else $error("empty result with wrong marker or bit count");

endmodule

// ===== hdl/hbpe_code_table.sv =====
module hbpe_code_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbpe_pkg::tbl_ctl_t ctl_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [DW-1:0]      wdata_i,
  output logic [DW-1:0]      rdata_o
);
  import hbpe_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DW-1:0] rdata_q;
  logic rvalid_q;

  // Entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule
